/* src/lssd_pkg.sv */
// ----------------------------------------------------------------------------
// lssd_pkg - shared types and constants
// Field widths, driver register map, configuration indexes and reset values
// for the LED shadow sync block.
// ----------------------------------------------------------------------------
package lssd_pkg;

	localparam int LED_W     = 4;            // width of an LED index
	localparam int LED_SLOTS = 1 << LED_W;   // addressable LED slots
	localparam int GROUPS    = 4;            // packed 4-LED state groups
	localparam int GRP_W     = 2;
	localparam int ST_W      = 2;
	localparam int PWR_W     = 8;
	localparam int ADDR_W    = 5;
	localparam int MASK_W    = 15;
	localparam int TMO_W     = 16;
	localparam int SYNC_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	localparam logic [ADDR_W-1:0] PWR_BASE = 5'd2;
	localparam logic [ADDR_W-1:0] GRP_BASE = 5'd20;
	localparam logic [ST_W-1:0]   ST_MASK  = 2'h3;
	localparam logic [PWR_W-1:0]  PWR_FULL = 8'hFF;

	localparam logic [PWR_W-1:0]  DIM_RST    = 8'd32;
	localparam logic [PWR_W-1:0]  BRIGHT_RST = 8'd255;
	localparam logic [TMO_W-1:0]  TMO_RST    = 16'd300;
	localparam logic [SYNC_W-1:0] PERIOD_RST = 8'd10;
	localparam logic [MASK_W-1:0] MASK_RST   = 15'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIM     = 3'd0,
		CFG_BRIGHT  = 3'd1,
		CFG_TIMEOUT = 3'd2,
		CFG_PERIOD  = 3'd3,
		CFG_MASK    = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_SET_STATE = 2'd0,
		MODE_SET_POWER = 2'd1,
		MODE_TICK      = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} fsm_t;

	typedef struct packed {
		logic [PWR_W-1:0]  dim;
		logic [PWR_W-1:0]  bright;
		logic [TMO_W-1:0]  timeout;
		logic [SYNC_W-1:0] period;
		logic [MASK_W-1:0] mask;
	} cfg_t;

	// controller to shadow store
	typedef struct packed {
		logic              set_state;
		logic              set_power;
		logic [LED_W-1:0]  idx;
		logic [PWR_W-1:0]  val;
		logic              mask_en;
		logic [PWR_W-1:0]  level;
		logic              copy_power;
		logic              copy_group;
		logic [LED_W-1:0]  rd_led;
		logic [GRP_W-1:0]  rd_grp;
	} shd_cmd_t;

	// shadow store to controller
	typedef struct packed {
		logic [PWR_W-1:0] want_pwr;
		logic [PWR_W-1:0] sent_pwr;
		logic [PWR_W-1:0] want_grp;
		logic [PWR_W-1:0] sent_grp;
	} shd_rd_t;

endpackage

/* src/led_shadow_sync_with_idle_dimming_core.sv */
// ----------------------------------------------------------------------------
// led_shadow_sync_with_idle_dimming_core - LED driver shadow synchronizer
// Keeps wanted and sent LED shadows, dims backlit LEDs when idle and turns
// shadow differences into driver register writes.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per item: s_tuser selects set state, set
//   brightness or tick. A tick runs the idle rule and, every sync period,
//   a sync scan that walks NUM_LEDS brightness entries and four state
//   groups through one comparator, one per cycle unless the receiver stalls
//   while two writes are waiting. m_* carries driver writes (address,
//   byte); m_tlast marks the final write of a tick. Quiet ticks and set
//   requests produce nothing. s_tready is low during the scan.
//   A found write is held back until the next one is found or the scan ends,
//   then moves to the output register; a stalled receiver holds the scan
//   only when a third write is due; a lone write waits for the scan to end.
//   Reset (arst_n low) restores shadows, counters, config and valid flags, not the
//   write address/data registers; the first sync rewrites every state group.
//   Configuration is written through cfg_we / cfg_addr / cfg_data while idle.
// ----------------------------------------------------------------------------
module led_shadow_sync_with_idle_dimming_core import lssd_pkg::*; #(
	parameter int NUM_LEDS = 15
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // led_index[3:0], value[11:4], key_pressed[12]
	input  logic [1:0]           s_tuser,   // mode[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // reg_addr[4:0], reg_data[12:5]
	output logic                 m_tlast,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t              cfg_q;
	shd_cmd_t          cmd;
	shd_rd_t           rd;
	logic [ADDR_W-1:0] out_addr;
	logic [PWR_W-1:0]  out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim     <= DIM_RST;
			cfg_q.bright  <= BRIGHT_RST;
			cfg_q.timeout <= TMO_RST;
			cfg_q.period  <= PERIOD_RST;
			cfg_q.mask    <= MASK_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_DIM:     cfg_q.dim     <= cfg_data[PWR_W-1:0];
				CFG_BRIGHT:  cfg_q.bright  <= cfg_data[PWR_W-1:0];
				CFG_TIMEOUT: cfg_q.timeout <= cfg_data[TMO_W-1:0];
				CFG_PERIOD:  cfg_q.period  <= cfg_data[SYNC_W-1:0];
				CFG_MASK:    cfg_q.mask    <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	lssd_ctrl #(
		.NUM_LEDS (NUM_LEDS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.in_idx    (s_tdata[3:0]),
		.in_val    (s_tdata[11:4]),
		.in_key    (s_tdata[12]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_addr  (out_addr),
		.out_data  (out_data),
		.out_last  (m_tlast),
		.cmd       (cmd),
		.rd        (rd)
	);

	lssd_shadow #(
		.NUM_LEDS (NUM_LEDS)
	) u_shadow (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.rd     (rd)
	);

	assign m_tdata = {3'b000, out_data, out_addr};

endmodule

/* src/lssd_shadow.sv */
// ----------------------------------------------------------------------------
// lssd_shadow - wanted and sent LED shadows
// Holds per-LED state and brightness shadows, applies set and masked writes,
// copies wanted to sent during a sync and packs the 4-LED state groups.
// ----------------------------------------------------------------------------
module lssd_shadow import lssd_pkg::*; #(
	parameter int NUM_LEDS = 15
) (
	input  logic     clk,
	input  logic     arst_n,
	input  shd_cmd_t cmd,
	input  cfg_t     cfg,
	output shd_rd_t  rd
);

	logic [ST_W-1:0]  want_st_q  [LED_SLOTS];
	logic [ST_W-1:0]  sent_st_q  [LED_SLOTS];
	logic [PWR_W-1:0] want_pwr_q [LED_SLOTS];
	logic [PWR_W-1:0] sent_pwr_q [LED_SLOTS];

	logic [LED_SLOTS-1:0] mask_x;
	logic                 idx_ok;

	assign mask_x = LED_SLOTS'(cfg.mask);
	assign idx_ok = {1'b0, cmd.idx} < (LED_W + 1)'(NUM_LEDS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LED_SLOTS; i++) begin
				want_st_q[i]  <= '0;
				sent_st_q[i]  <= ST_MASK;
				want_pwr_q[i] <= PWR_FULL;
				sent_pwr_q[i] <= PWR_FULL;
			end
		end else begin
			if (cmd.set_state && idx_ok) begin
				want_st_q[cmd.idx] <= cmd.val[ST_W-1:0];
			end
			if (cmd.set_power && idx_ok) begin
				want_pwr_q[cmd.idx] <= cmd.val;
			end
			if (cmd.mask_en) begin
				for (int i = 0; i < LED_SLOTS; i++) begin
					if (mask_x[i] && (i < NUM_LEDS)) begin
						want_pwr_q[i] <= cmd.level;
					end
				end
			end
			if (cmd.copy_power) begin
				sent_pwr_q[cmd.rd_led] <= want_pwr_q[cmd.rd_led];
			end
			if (cmd.copy_group) begin
				for (int k = 0; k < 4; k++) begin
					sent_st_q[{cmd.rd_grp, 2'(k)}] <= want_st_q[{cmd.rd_grp, 2'(k)}];
				end
			end
		end
	end

	// bit 0 is always clear; the top bit of the fourth slot falls off the byte
	always_comb begin
		logic [LED_W-1:0] lid;
		logic [ST_W-1:0]  ws;
		logic [ST_W-1:0]  ss;
		rd.want_pwr = want_pwr_q[cmd.rd_led];
		rd.sent_pwr = sent_pwr_q[cmd.rd_led];
		rd.want_grp = '0;
		rd.sent_grp = '0;
		for (int k = 0; k < 4; k++) begin
			lid = {cmd.rd_grp, 2'(k)};
			if ({1'b0, lid} < (LED_W + 1)'(NUM_LEDS)) begin
				ws = want_st_q[lid];
				ss = sent_st_q[lid];
			end else begin
				ws = '0;
				ss = '0;
			end
			rd.want_grp[2*k+1] = ws[0];
			rd.sent_grp[2*k+1] = ss[0];
			if (k < 3) begin
				rd.want_grp[2*k+2] = ws[1];
				rd.sent_grp[2*k+2] = ss[1];
			end
		end
	end

endmodule

/* src/lssd_ctrl.sv */
// ----------------------------------------------------------------------------
// lssd_ctrl - item sequencer and sync scanner
// Runs the idle and sync counters on ticks, then walks the brightness entries
// and state groups through one shared comparator, emitting driver writes.
// ----------------------------------------------------------------------------
module lssd_ctrl import lssd_pkg::*; #(
	parameter int NUM_LEDS = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_mode,
	input  logic [LED_W-1:0]  in_idx,
	input  logic [PWR_W-1:0]  in_val,
	input  logic              in_key,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] out_addr,
	output logic [PWR_W-1:0]  out_data,
	output logic              out_last,
	output shd_cmd_t          cmd,
	input  shd_rd_t           rd
);

	localparam int SCAN_N = NUM_LEDS + GROUPS;
	localparam int SCAN_W = $clog2(SCAN_N);
	localparam logic [SCAN_W-1:0] SCAN_END  = SCAN_W'(SCAN_N - 1);
	localparam logic [SCAN_W-1:0] SCAN_GRP0 = SCAN_W'(NUM_LEDS);

	fsm_t state_q, state_d;

	logic [SCAN_W-1:0] scan_q;
	logic [TMO_W-1:0]  idle_q, idle_d;
	logic              bright_q, bright_d;
	logic [SYNC_W-1:0] sync_q, sync_d;
	logic              pend_valid_q;
	logic [ADDR_W-1:0] pend_addr_q;
	logic [PWR_W-1:0]  pend_data_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [PWR_W-1:0]  out_data_q;
	logic              out_last_q;

	logic              accept, tick, start_sync, sync_hit;
	logic              is_pwr, differ, slot_free, advance;
	logic              push_mid, push_end, take_new;
	logic [PWR_W-1:0]  cmp_a, cmp_b;
	logic [LED_W-1:0]  led_idx;
	logic [GRP_W-1:0]  grp_idx;
	logic [ADDR_W-1:0] new_addr;
	logic [TMO_W-1:0]  idle_inc;
	logic [SYNC_W-1:0] sync_inc;
	logic              mask_en;
	logic [PWR_W-1:0]  mask_level;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign tick      = accept && (in_mode == MODE_TICK);
	assign slot_free = !out_valid_q || out_ready;

	// idle rule and sync counter
	assign idle_inc = idle_q + 1'b1;
	always_comb begin
		idle_d     = idle_q;
		bright_d   = bright_q;
		mask_en    = 1'b0;
		mask_level = cfg.bright;
		if (in_key) begin
			idle_d = '0;
			if (!bright_q) begin
				bright_d = 1'b1;
				mask_en  = tick;
			end
		end else if (idle_q < cfg.timeout) begin
			idle_d = idle_inc;
			if ((idle_inc >= cfg.timeout) && bright_q) begin
				bright_d   = 1'b0;
				mask_en    = tick;
				mask_level = cfg.dim;
			end
		end
	end

	always_comb begin
		sync_inc = (sync_q < cfg.period) ? sync_q + 1'b1 : sync_q;
		sync_hit = (sync_inc >= cfg.period);
		sync_d   = sync_hit ? '0 : sync_inc;
	end

	assign start_sync = tick && sync_hit;

	// shared comparator over brightness entries, then packed groups
	assign is_pwr  = (scan_q < SCAN_GRP0);
	assign led_idx = LED_W'(scan_q);
	assign grp_idx = GRP_W'(scan_q - SCAN_GRP0);
	assign cmp_a   = is_pwr ? rd.want_pwr : rd.want_grp;
	assign cmp_b   = is_pwr ? rd.sent_pwr : rd.sent_grp;
	assign differ  = (cmp_a != cmp_b);
	assign new_addr = is_pwr ? PWR_BASE + ADDR_W'(led_idx) : GRP_BASE + ADDR_W'(grp_idx);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start_sync) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (advance && (scan_q == SCAN_END)) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!pend_valid_q || slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		advance  = 1'b0;
		push_mid = 1'b0;
		push_end = 1'b0;
		unique case (state_q)
			ST_IDLE: ;
			ST_SCAN: begin
				// a second write can only go out once the held one has a slot
				advance  = !differ || !pend_valid_q || slot_free;
				push_mid = differ && pend_valid_q && slot_free;
			end
			ST_FLUSH: begin
				push_end = pend_valid_q && slot_free;
			end
			default: ;
		endcase
		take_new = advance && differ;

		cmd            = '0;
		cmd.set_state  = accept && (in_mode == MODE_SET_STATE);
		cmd.set_power  = accept && (in_mode == MODE_SET_POWER);
		cmd.idx        = in_idx;
		cmd.val        = in_val;
		cmd.mask_en    = mask_en;
		cmd.level      = mask_level;
		cmd.copy_power = take_new && is_pwr;
		cmd.copy_group = take_new && !is_pwr;
		cmd.rd_led     = led_idx;
		cmd.rd_grp     = grp_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_q       <= '0;
			idle_q       <= '0;
			bright_q     <= 1'b0;
			sync_q       <= PERIOD_RST;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (tick) begin
				idle_q   <= idle_d;
				bright_q <= bright_d;
				sync_q   <= sync_d;
			end
			if (start_sync) begin
				scan_q <= '0;
			end else if (advance) begin
				scan_q <= scan_q + 1'b1;
			end
			if (take_new) begin
				pend_valid_q <= 1'b1;
			end else if (push_end) begin
				pend_valid_q <= 1'b0;
			end
			if (push_mid || push_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_new) begin
			pend_addr_q <= new_addr;
			pend_data_q <= cmp_a;
		end
		if (push_mid || push_end) begin
			out_addr_q <= pend_addr_q;
			out_data_q <= pend_data_q;
			out_last_q <= push_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_addr  = out_addr_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for led_shadow_sync_with_idle_dimming_core
// Drives set-state, set-brightness, tick and unused requests over the slave
// stream and checks every driver write on the master stream against an
// in-bench shadow model, over several register settings and random stalls.
// ----------------------------------------------------------------------------
module tb;
	import lssd_pkg::*;

	localparam int N_LEDS = 15;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [PWR_W-1:0]  data;
		logic              last;
	} drv_write_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;
	logic [1:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [15:0]          m_tdata;
	logic                 m_tlast;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_W-1:0]     cfg_data;

	// shadow model of the block
	logic [ST_W-1:0]   want_st [N_LEDS];
	logic [PWR_W-1:0]  want_pw [N_LEDS];
	logic [ST_W-1:0]   sent_st [N_LEDS];
	logic [PWR_W-1:0]  sent_pw [N_LEDS];
	logic [TMO_W-1:0]  idle_cnt;
	logic              bright_on;
	logic [SYNC_W-1:0] sync_cnt;
	logic [PWR_W-1:0]  dim_lvl;
	logic [PWR_W-1:0]  bright_lvl;
	logic [TMO_W-1:0]  idle_tmo;
	logic [SYNC_W-1:0] sync_per;
	logic [MASK_W-1:0] backlit;

	drv_write_t expected_writes[$];
	drv_write_t held_write;
	bit         have_held;

	bit burst;
	int errors;
	int n_requests;
	int n_ticks;
	int n_writes;
	int n_settings;

	led_shadow_sync_with_idle_dimming_core #(
		.NUM_LEDS(N_LEDS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.cfg_we  (cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [PWR_W-1:0] packed_states(bit from_sent, int g);
		int v;
		int idx;
		logic [ST_W-1:0] st;
		v = 0;
		for (int k = 0; k < 4; k++) begin
			idx = g * 4 + k;
			st = '0;
			if (idx < N_LEDS)
				st = from_sent ? sent_st[idx] : want_st[idx];
			v = v | ((int'(st) << 1) << (2 * k));
		end
		return v[PWR_W-1:0];
	endfunction

	function automatic void apply_level(logic [PWR_W-1:0] lvl);
		for (int i = 0; i < N_LEDS; i++)
			if (backlit[i])
				want_pw[i] = lvl;
	endfunction

	// hold one write back so the final one of a tick can be marked last
	function automatic void queue_write(logic [ADDR_W-1:0] a, logic [PWR_W-1:0] d);
		if (have_held)
			expected_writes.push_back(held_write);
		held_write.addr = a;
		held_write.data = d;
		held_write.last = 1'b0;
		have_held = 1'b1;
	endfunction

	function automatic void shadow_request(logic [1:0] md, logic [3:0] li, logic [7:0] v,
			logic k);
		logic [PWR_W-1:0] wv;
		logic [PWR_W-1:0] sv;
		int idx;
		case (md)
			MODE_SET_STATE: begin
				if (li < N_LEDS)
					want_st[li] = v[ST_W-1:0];
			end
			MODE_SET_POWER: begin
				if (li < N_LEDS)
					want_pw[li] = v;
			end
			MODE_TICK: begin
				if (k) begin
					idle_cnt = '0;
					if (!bright_on) begin
						bright_on = 1'b1;
						apply_level(bright_lvl);
					end
				end else if (idle_cnt < idle_tmo) begin
					idle_cnt = idle_cnt + 1'b1;
					if (idle_cnt >= idle_tmo && bright_on) begin
						bright_on = 1'b0;
						apply_level(dim_lvl);
					end
				end
				if (sync_cnt < sync_per)
					sync_cnt = sync_cnt + 1'b1;
				if (sync_cnt >= sync_per) begin
					sync_cnt = '0;
					have_held = 1'b0;
					for (int i = 0; i < N_LEDS; i++) begin
						if (want_pw[i] != sent_pw[i]) begin
							queue_write(ADDR_W'(PWR_BASE + i), want_pw[i]);
							sent_pw[i] = want_pw[i];
						end
					end
					for (int g = 0; g < GROUPS; g++) begin
						wv = packed_states(1'b0, g);
						sv = packed_states(1'b1, g);
						if (wv != sv) begin
							queue_write(ADDR_W'(GRP_BASE + g), wv);
							for (int j = 0; j < 4; j++) begin
								idx = g * 4 + j;
								if (idx < N_LEDS)
									sent_st[idx] = want_st[idx];
							end
						end
					end
					if (have_held) begin
						held_write.last = 1'b1;
						expected_writes.push_back(held_write);
						have_held = 1'b0;
					end
				end
			end
			default: ;
		endcase
	endfunction

	// called at a falling edge, returns at a falling edge with tvalid still high
	task automatic send_request(logic [1:0] md, logic [3:0] li, logic [7:0] v, logic k);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = {3'b000, k, v, li};
		s_tuser  = md;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		shadow_request(md, li, v, k);
		n_requests++;
		if (md == MODE_TICK)
			n_ticks++;
		@(negedge clk);
	endtask

	// drop the request, drain all expected writes, then let the scan finish
	task automatic settle(int extra);
		s_tvalid = 1'b0;
		while (expected_writes.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] d);
		cfg_we   = 1'b1;
		cfg_addr = idx;
		cfg_data = d;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_DIM:     dim_lvl    = d[PWR_W-1:0];
			CFG_BRIGHT:  bright_lvl = d[PWR_W-1:0];
			CFG_TIMEOUT: idle_tmo   = d[TMO_W-1:0];
			CFG_PERIOD:  sync_per   = d[SYNC_W-1:0];
			CFG_MASK:    backlit    = d[MASK_W-1:0];
			default: ;
		endcase
	endtask

	// first tick after reset rewrites every state group
	task automatic test_first_sync();
		send_request(MODE_TICK, 4'd0, 8'h00, 1'b0);
	endtask

	task automatic test_set_requests();
		settle(40);
		write_reg(CFG_PERIOD, 16'd0);
		n_settings++;
		send_request(MODE_SET_STATE, 4'd0, 8'hFF, 1'b0);
		send_request(MODE_SET_STATE, 4'd14, 8'h02, 1'b1);
		send_request(MODE_SET_STATE, 4'd15, 8'hFF, 1'b1);
		send_request(MODE_SET_POWER, 4'd0, 8'h00, 1'b0);
		send_request(MODE_SET_POWER, 4'd14, 8'h80, 1'b0);
		send_request(MODE_SET_POWER, 4'd15, 8'h00, 1'b0);
		send_request(MODE_UNUSED, 4'd15, 8'hFF, 1'b1);
		send_request(MODE_TICK, 4'd0, 8'h00, 1'b0);
		// top slot of a group spills past bit 7
		send_request(MODE_SET_STATE, 4'd3, 8'h03, 1'b0);
		send_request(MODE_SET_STATE, 4'd2, 8'h01, 1'b0);
		send_request(MODE_TICK, 4'd15, 8'hFF, 1'b0);
		send_request(MODE_TICK, 4'd0, 8'h00, 1'b0);
	endtask

	task automatic test_idle_dimming();
		settle(40);
		write_reg(CFG_DIM, 16'd0);
		write_reg(CFG_BRIGHT, 16'd255);
		write_reg(CFG_TIMEOUT, 16'd3);
		write_reg(CFG_MASK, 16'hFFFF);
		n_settings++;
		send_request(MODE_TICK, 4'd0, 8'h00, 1'b1);
		repeat (3) send_request(MODE_TICK, 4'd0, 8'h00, 1'b0);
		// zero timeout: never dim again
		settle(40);
		write_reg(CFG_DIM, 16'd255);
		write_reg(CFG_BRIGHT, 16'd0);
		write_reg(CFG_TIMEOUT, 16'd0);
		n_settings++;
		send_request(MODE_TICK, 4'd0, 8'h00, 1'b1);
		repeat (2) send_request(MODE_TICK, 4'd0, 8'h00, 1'b0);
		settle(40);
		write_reg(CFG_TIMEOUT, 16'hFFFF);
		write_reg(CFG_PERIOD, 16'd1);
		n_settings++;
		repeat (2) send_request(MODE_TICK, 4'd0, 8'h00, 1'b0);
	endtask

	task automatic test_random(int n_phases, int per_phase);
		int r;
		logic [1:0] md;
		for (int p = 0; p < n_phases; p++) begin
			settle(40);
			burst = (p == 1);
			r = $urandom_range(0, 3);
			write_reg(CFG_DIM, r == 0 ? 16'd0 : r == 1 ? 16'd255 : 16'($urandom_range(0, 255)));
			r = $urandom_range(0, 3);
			write_reg(CFG_BRIGHT, r == 0 ? 16'd0 : r == 1 ? 16'd255 :
				16'($urandom_range(0, 255)));
			r = $urandom_range(0, 4);
			write_reg(CFG_TIMEOUT, r == 0 ? 16'd0 : r == 1 ? 16'd1 : r == 2 ? 16'hFFFF :
				16'($urandom_range(1, 12)));
			write_reg(CFG_PERIOD, p == n_phases - 1 ? 16'd255 : 16'($urandom_range(0, 4)));
			r = $urandom_range(0, 3);
			write_reg(CFG_MASK, r == 0 ? 16'd0 : r == 1 ? 16'h7FFF :
				16'($urandom_range(0, 65535)));
			n_settings++;
			for (int i = 0; i < per_phase; i++) begin
				// hold off until the block has drained
				if (i == per_phase / 2 && p % 2 == 0)
					settle(0);
				r = $urandom_range(0, 99);
				md = r < 40 ? MODE_TICK : r < 65 ? MODE_SET_STATE :
					r < 92 ? MODE_SET_POWER : MODE_UNUSED;
				send_request(md, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
					$urandom_range(0, 3) == 0);
			end
		end
		burst = 1'b0;
	endtask

	// receiver: random stall before each write
	initial begin
		int stall;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			stall = burst ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		drv_write_t exp_w;
		if (arst_n && m_tvalid && m_tready) begin
			n_writes++;
			if (expected_writes.size() == 0) begin
				errors++;
				$display("%0t: unexpected write addr %0d data %0h last %0b", $realtime,
					m_tdata[4:0], m_tdata[12:5], m_tlast);
			end else begin
				exp_w = expected_writes.pop_front();
				if (m_tdata[4:0] !== exp_w.addr) begin
					errors++;
					$display("%0t: reg_addr expected %0d actual %0d", $realtime,
						exp_w.addr, m_tdata[4:0]);
				end
				if (m_tdata[12:5] !== exp_w.data) begin
					errors++;
					$display("%0t: reg_data expected %0h actual %0h", $realtime,
						exp_w.data, m_tdata[12:5]);
				end
				if (m_tlast !== exp_w.last) begin
					errors++;
					$display("%0t: last expected %0b actual %0b", $realtime,
						exp_w.last, m_tlast);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		cfg_we   = 1'b0;
		cfg_addr = CFG_DIM;
		cfg_data = '0;
		burst    = 1'b0;
		errors   = 0;
		n_requests = 0;
		n_ticks    = 0;
		n_writes   = 0;
		n_settings = 1;
		have_held  = 1'b0;
		for (int i = 0; i < N_LEDS; i++) begin
			want_st[i] = '0;
			want_pw[i] = PWR_FULL;
			sent_st[i] = ST_MASK;
			sent_pw[i] = PWR_FULL;
		end
		dim_lvl    = DIM_RST;
		bright_lvl = BRIGHT_RST;
		idle_tmo   = TMO_RST;
		sync_per   = PERIOD_RST;
		backlit    = MASK_RST;
		idle_cnt   = '0;
		bright_on  = 1'b0;
		sync_cnt   = PERIOD_RST;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_first_sync();
		test_set_requests();
		test_idle_dimming();
		test_random(5, 50);
		settle(40);

		$display("covered %0d requests (%0d ticks) under %0d register settings",
			n_requests, n_ticks, n_settings);
		$display("checked %0d driver writes, %0d mismatches", n_writes, errors);
		if (errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

/* files.f */
src/lssd_pkg.sv
src/lssd_shadow.sv
src/lssd_ctrl.sv
src/led_shadow_sync_with_idle_dimming_core.sv
tb/sv/tb.sv
